FILE: rtl/core/brle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_pkg
// Shared types and constants of the byte run-length encoder.
// ----------------------------------------------------------------------------
package brle_pkg;

  localparam int unsigned MaxBlockDefault = 127;
  localparam int unsigned LenW            = 7;   // literal / run length width
  localparam int unsigned CmdDepth        = 4;
  localparam logic [7:0]  RunMark         = 8'h80;

  typedef enum logic [1:0] {
    CMD_RUN,
    CMD_LIT,
    CMD_END
  } cmd_kind_e;

  // One command from the front to the back.
  typedef struct packed {
    cmd_kind_e         kind;
    logic [LenW-1:0]   len;
    logic [7:0]        val;
    logic              bank;
  } cmd_t;

  // Literal store write port, front to back.
  typedef struct packed {
    logic              en;
    logic              bank;
    logic [LenW-1:0]   idx;
    logic [7:0]        data;
  } mem_wr_t;

  // Literal bank release, back to front.
  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

endpackage

FILE: rtl/core/brle_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_in_if
// Raw byte channel: valid/ready handshake with byte and end-of-block flag.
// ----------------------------------------------------------------------------
interface brle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: rtl/core/brle_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_out_if
// Encoded word channel: valid/ready handshake with packed word, count, flag.
// ----------------------------------------------------------------------------
interface brle_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_word;
  logic [3:0]  out_count;
  logic        out_last;

  modport source (output valid, output out_word, output out_count, output out_last,
                  input ready);
  modport sink   (input valid, input out_word, input out_count, input out_last,
                  output ready);
endinterface

FILE: rtl/core/brle_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_cmd_fifo
// Small command queue between the classifier front and the emitter back.
// ----------------------------------------------------------------------------
module brle_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  brle_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output brle_pkg::cmd_t pop_data_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = $clog2(brle_pkg::CmdDepth);
  localparam int unsigned CntW = $clog2(brle_pkg::CmdDepth + 1);

  brle_pkg::cmd_t mem_q [brle_pkg::CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(brle_pkg::CmdDepth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(brle_pkg::CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(brle_pkg::CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("command pushed into full queue");

endmodule

FILE: rtl/core/brle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_front
// Classifies raw bytes into runs and literals, fills the literal banks and
// issues commands; closes the block through its tail states (run, two lookahead bytes, literal, end).
// ----------------------------------------------------------------------------
module brle_front #(
  parameter int unsigned MaxBlock = brle_pkg::MaxBlockDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  brle_in_if.sink           in_i,
  output logic              push_o,
  output brle_pkg::cmd_t    cmd_o,
  input  logic              full_i,
  output brle_pkg::mem_wr_t wr_o,
  input  brle_pkg::rel_t    rel_i
);

  localparam int unsigned LenW = brle_pkg::LenW;

  localparam logic [2:0] P_IN  = 3'd0;
  localparam logic [2:0] P_RUN = 3'd1;
  localparam logic [2:0] P_LA0 = 3'd2;
  localparam logic [2:0] P_LA1 = 3'd3;
  localparam logic [2:0] P_LIT = 3'd4;
  localparam logic [2:0] P_END = 3'd5;

  logic [2:0]      phase_q, phase_d;
  logic [LenW-1:0] lit_len_q, lit_len_d;
  logic [7:0]      run_val_q, run_val_d;
  logic [LenW-1:0] run_len_q, run_len_d;
  logic [7:0]      la_q [2];
  logic [7:0]      la_d [2];
  logic [1:0]      la_cnt_q, la_cnt_d;
  logic            bank_q, bank_d;
  logic [1:0]      busy_q, busy_d;

  logic            step_ok, go;
  logic            add_en;
  logic [7:0]      add_byte;
  logic [LenW-1:0] lit_len_inc;

  assign step_ok  = !full_i && !busy_q[bank_q];
  assign in_i.ready = (phase_q == P_IN) && step_ok;
  assign go       = (phase_q == P_IN) ? (in_i.valid && step_ok) : step_ok;
  assign lit_len_inc = lit_len_q + 1'b1;

  always_comb begin
    phase_d   = phase_q;
    lit_len_d = lit_len_q;
    run_val_d = run_val_q;
    run_len_d = run_len_q;
    la_d      = la_q;
    la_cnt_d  = la_cnt_q;
    bank_d    = bank_q;
    push_o    = 1'b0;
    cmd_o     = '{kind: brle_pkg::CMD_END, len: lit_len_q, val: run_val_q, bank: bank_q};
    add_en    = 1'b0;
    add_byte  = la_q[0];

    if (go) begin
      unique case (phase_q)
        P_IN: begin
          if (run_len_q != '0) begin
            if (in_i.in_byte == run_val_q && run_len_q < LenW'(MaxBlock)) begin
              run_len_d = run_len_q + 1'b1;
            end else begin
              push_o    = 1'b1;
              cmd_o     = '{kind: brle_pkg::CMD_RUN, len: run_len_q, val: run_val_q,
                            bank: bank_q};
              run_len_d = '0;
              la_d[0]   = in_i.in_byte;
              la_cnt_d  = 2'd1;
            end
          end else if (la_cnt_q < 2'd2) begin
            la_d[la_cnt_q[0]] = in_i.in_byte;
            la_cnt_d          = la_cnt_q + 1'b1;
          end else if (la_q[0] == la_q[1] && la_q[1] == in_i.in_byte) begin
            if (lit_len_q != '0) begin
              push_o    = 1'b1;
              cmd_o     = '{kind: brle_pkg::CMD_LIT, len: lit_len_q, val: run_val_q,
                            bank: bank_q};
              bank_d    = !bank_q;
              lit_len_d = '0;
            end
            run_val_d = la_q[0];
            run_len_d = LenW'(3);
            la_cnt_d  = 2'd0;
          end else begin
            add_en   = 1'b1;
            add_byte = la_q[0];
            la_d[0]  = la_q[1];
            la_d[1]  = in_i.in_byte;
          end
          if (in_i.in_last) begin
            phase_d = P_RUN;
          end
        end
        P_RUN: begin
          if (run_len_q != '0) begin
            push_o    = 1'b1;
            cmd_o     = '{kind: brle_pkg::CMD_RUN, len: run_len_q, val: run_val_q,
                          bank: bank_q};
            run_len_d = '0;
          end
          phase_d = P_LA0;
        end
        P_LA0: begin
          add_en   = (la_cnt_q != 2'd0);
          add_byte = la_q[0];
          phase_d  = P_LA1;
        end
        P_LA1: begin
          add_en   = (la_cnt_q == 2'd2);
          add_byte = la_q[1];
          la_cnt_d = 2'd0;
          phase_d  = P_LIT;
        end
        P_LIT: begin
          if (lit_len_q != '0) begin
            push_o    = 1'b1;
            cmd_o     = '{kind: brle_pkg::CMD_LIT, len: lit_len_q, val: run_val_q,
                          bank: bank_q};
            bank_d    = !bank_q;
            lit_len_d = '0;
          end
          phase_d = P_END;
        end
        P_END: begin
          push_o    = 1'b1;
          cmd_o     = '{kind: brle_pkg::CMD_END, len: lit_len_q, val: run_val_q,
                        bank: bank_q};
          run_val_d = '0;
          la_d[0]   = '0;
          la_d[1]   = '0;
          phase_d   = P_IN;
        end
        default: phase_d = P_IN;
      endcase

      // literal append; a full block goes out at once
      if (add_en) begin
        if (lit_len_inc == LenW'(MaxBlock)) begin
          push_o    = 1'b1;
          cmd_o     = '{kind: brle_pkg::CMD_LIT, len: lit_len_inc, val: run_val_q,
                        bank: bank_q};
          bank_d    = !bank_q;
          lit_len_d = '0;
        end else begin
          lit_len_d = lit_len_inc;
        end
      end
    end
  end

  assign wr_o = '{en: go && add_en, bank: bank_q, idx: lit_len_q, data: add_byte};

  always_comb begin
    busy_d = busy_q;
    if (rel_i.en) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (push_o && cmd_o.kind == brle_pkg::CMD_LIT) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= P_IN;
      lit_len_q <= '0;
      run_val_q <= '0;
      run_len_q <= '0;
      la_q[0]   <= '0;
      la_q[1]   <= '0;
      la_cnt_q  <= '0;
      bank_q    <= 1'b0;
      busy_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      lit_len_q <= lit_len_d;
      run_val_q <= run_val_d;
      run_len_q <= run_len_d;
      la_q      <= la_d;
      la_cnt_q  <= la_cnt_d;
      bank_q    <= bank_d;
      busy_q    <= busy_d;
    end
  end

  a_wr_free_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> !busy_q[wr_o.bank])
    else $error("literal write into a bank still draining");

  a_run_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_len_q != '0) |-> (run_len_q >= LenW'(3) && run_len_q <= LenW'(MaxBlock)))
    else $error("open run length out of range");

endmodule

FILE: rtl/core/brle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_back
// Executes commands: holds the literal banks, serializes encoded bytes and
// packs them into 8-byte output words.
// ----------------------------------------------------------------------------
module brle_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  brle_pkg::cmd_t    cmd_i,
  input  logic              empty_i,
  output logic              pop_o,
  input  brle_pkg::mem_wr_t wr_i,
  output brle_pkg::rel_t    rel_o,
  brle_out_if.source        out_o
);

  localparam int unsigned LenW = brle_pkg::LenW;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_RUN_H = 3'd1;
  localparam logic [2:0] B_RUN_V = 3'd2;
  localparam logic [2:0] B_LIT_H = 3'd3;
  localparam logic [2:0] B_LIT_D = 3'd4;
  localparam logic [2:0] B_END   = 3'd5;

  // two literal banks
  logic [7:0] lit_mem [2**(LenW+1)];
  logic [7:0] rdata_q;

  logic [2:0]      state_q, state_d;
  brle_pkg::cmd_t  cur_q, cur_d;
  logic [LenW-1:0] idx_q, idx_d;

  logic [63:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        ov_q, ov_d;
  logic [63:0] ow_q, ow_d;
  logic [3:0]  oc_q, oc_d;
  logic        ol_q, ol_d;

  logic        out_free, put_ok, put_en;
  logic [7:0]  put_byte;

  assign out_free = !ov_q || out_o.ready;
  assign put_ok   = (cnt_q != 4'd8) || out_free;
  assign pop_o    = (state_q == B_IDLE) && !empty_i;

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    idx_d    = idx_q;
    put_en   = 1'b0;
    put_byte = rdata_q;
    rel_o    = '{en: 1'b0, bank: cur_q.bank};
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          cur_d = cmd_i;
          unique case (cmd_i.kind)
            brle_pkg::CMD_RUN: state_d = B_RUN_H;
            brle_pkg::CMD_LIT: state_d = B_LIT_H;
            default:           state_d = B_END;
          endcase
        end
      end
      B_RUN_H: begin
        put_en   = 1'b1;
        put_byte = brle_pkg::RunMark | 8'(cur_q.len);
        if (put_ok) state_d = B_RUN_V;
      end
      B_RUN_V: begin
        put_en   = 1'b1;
        put_byte = cur_q.val;
        if (put_ok) state_d = B_IDLE;
      end
      B_LIT_H: begin
        put_en   = 1'b1;
        put_byte = 8'(cur_q.len);
        idx_d    = '0;
        if (put_ok) state_d = B_LIT_D;
      end
      B_LIT_D: begin
        put_en   = 1'b1;
        put_byte = rdata_q;
        if (put_ok) begin
          if (idx_q == cur_q.len - 1'b1) begin
            rel_o.en = 1'b1;
            state_d  = B_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      B_END: begin
        if (out_free) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // byte packer and output register
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    ov_d  = ov_q && !out_o.ready;
    ow_d  = ow_q;
    oc_d  = oc_q;
    ol_d  = ol_q;
    if (put_en && put_ok) begin
      if (cnt_q == 4'd8) begin
        ov_d  = 1'b1;
        ow_d  = acc_q;
        oc_d  = 4'd8;
        ol_d  = 1'b0;
        acc_d = {56'd0, put_byte};
        cnt_d = 4'd1;
      end else begin
        for (int k = 0; k < 8; k++) begin
          if (cnt_q[2:0] == 3'(k)) acc_d[8*k +: 8] = put_byte;
        end
        cnt_d = cnt_q + 1'b1;
      end
    end
    if (state_q == B_END && out_free && cnt_q != 4'd0) begin
      ov_d  = 1'b1;
      ow_d  = acc_q;
      oc_d  = cnt_q;
      ol_d  = 1'b1;
      acc_d = '0;
      cnt_d = 4'd0;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.out_word  = ow_q;
  assign out_o.out_count = oc_q;
  assign out_o.out_last  = ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      idx_q   <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    ow_q  <= ow_d;
    oc_q  <= oc_d;
    ol_q  <= ol_d;
  end

  // read address follows the next index so rdata_q matches idx_q
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      lit_mem[{wr_i.bank, wr_i.idx}] <= wr_i.data;
    end
    rdata_q <= lit_mem[{cur_d.bank, idx_d}];
  end

  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (oc_q != 4'd0 && oc_q <= 4'd8))
    else $error("output count out of range");

  a_mid_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !ol_q) |-> (oc_q == 4'd8))
    else $error("partial word emitted mid block");

endmodule

FILE: rtl/core/byte_run_length_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_run_length_encoder
// PackBits-style run-length encoder packing output into 8-byte words.
// ----------------------------------------------------------------------------
// The front takes one raw byte per cycle and, after the flagged last byte of
// a block, closes the block through its tail states (run, two lookahead
// bytes, literal, end). The back emits one encoded byte per cycle into the
// word packer, so sustained input rate follows the encoded byte count:
// literal data is held to the back's pace, long runs go much faster. Input
// stalls when the four-entry command queue is full, or when the literal
// bank the front would fill next is still being read out by the back; the
// two literal banks live in one 256-entry memory with one write and one
// read port. Output words wait in a register, so a stalled sink only blocks
// the back at a block end or once the packer has another full word ready.
// ----------------------------------------------------------------------------
module byte_run_length_encoder #(
  parameter int unsigned MaxBlock = brle_pkg::MaxBlockDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  brle_in_if.sink    in_i,
  brle_out_if.source out_o
);

  // front to queue
  brle_pkg::cmd_t    push_cmd;
  logic              push;
  logic              full;
  // queue to back
  brle_pkg::cmd_t    pop_cmd;
  logic              pop;
  logic              empty;
  // literal store write and bank release
  brle_pkg::mem_wr_t mem_wr;
  brle_pkg::rel_t    rel;

  brle_front #(
    .MaxBlock (MaxBlock)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .cmd_o  (push_cmd),
    .full_i (full),
    .wr_o   (mem_wr),
    .rel_i  (rel)
  );

  brle_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (empty)
  );

  brle_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (pop_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .wr_i    (mem_wr),
    .rel_o   (rel),
    .out_o   (out_o)
  );

endmodule
